### design/bchm_pkg.sv
// Shared types and constants for the button click / hold / multi-click detector.
// No dependencies; imported by every module of the block but bchm_checker.
package bchm_pkg;

    // Register addresses are word indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
    localparam logic [1:0] REG_HOLD        = 2'd1;
    localparam logic [1:0] REG_RELEASE_GAP = 2'd2;
    localparam logic [1:0] REG_PRESSED_LVL = 2'd3;

    localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [15:0] HOLD_RST        = 16'd1000;
    localparam logic [15:0] RELEASE_GAP_RST = 16'd400;
    localparam logic        PRESSED_LVL_RST = 1'b0;

    // Button state machine codes
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_HELD     = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
        logic [15:0] release_gap_ms;
        logic        pressed_level;
    } t_cfg;

    // Packed so that click_event sits in bit 0 of the output beat
    typedef struct packed {
        logic       is_pressed;
        logic [3:0] clicks_during_hold;
        logic [3:0] clicks_before_hold_start;
        logic [3:0] series_clicks;
        logic       hold_event;
        logic       release_event;
        logic       click_event;
    } t_result;

endpackage

### design/bchm_cfg_regs.sv
// APB-style configuration registers for the button detector.
// Depends on bchm_pkg (t_cfg, register addresses, reset values).
module bchm_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [3:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    output bchm_pkg::t_cfg   o_cfg
);
    import bchm_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign o_pready = 1'b1;
    assign idx      = i_paddr[3:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= DEBOUNCE_RST;
            r_cfg.hold_ms        <= HOLD_RST;
            r_cfg.release_gap_ms <= RELEASE_GAP_RST;
            r_cfg.pressed_level  <= PRESSED_LVL_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_DEBOUNCE:    r_cfg.debounce_ms    <= i_pwdata[15:0];
                REG_HOLD:        r_cfg.hold_ms        <= i_pwdata[15:0];
                REG_RELEASE_GAP: r_cfg.release_gap_ms <= i_pwdata[15:0];
                REG_PRESSED_LVL: r_cfg.pressed_level  <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (idx)
            REG_DEBOUNCE:    o_prdata = {16'd0, r_cfg.debounce_ms};
            REG_HOLD:        o_prdata = {16'd0, r_cfg.hold_ms};
            REG_RELEASE_GAP: o_prdata = {16'd0, r_cfg.release_gap_ms};
            REG_PRESSED_LVL: o_prdata = {31'd0, r_cfg.pressed_level};
            default:         o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### design/bchm_detect.sv
// Debounce and click / hold / series state machine, one poll per accepted beat.
// Depends on bchm_pkg (t_cfg, t_result, state codes).
module bchm_detect #(
    parameter int MAX_CLICKS = 15,
    parameter int TIME_BITS  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_raw_level,
    input  logic [31:0]        i_now_ms,
    input  bchm_pkg::t_cfg     i_cfg,
    output bchm_pkg::t_result  o_result
);
    import bchm_pkg::*;

    localparam int CW = $clog2(MAX_CLICKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CLICKS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic                 r_prev_level;
    logic [TIME_BITS-1:0] r_last_change;
    logic                 r_debounced;
    logic [1:0]           r_state;
    logic [TIME_BITS-1:0] r_phase_start;
    logic [CW-1:0]        r_count;

    logic                 n_debounced;
    logic [1:0]           n_state;
    logic [TIME_BITS-1:0] n_phase_start;
    logic [CW-1:0]        n_count;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] stable_for;
    logic [TIME_BITS-1:0] phase_for;
    logic [TIME_BITS-1:0] phase_limit;
    logic                 changed;
    logic                 stable;
    logic                 pressed;
    logic                 phase_done;
    logic [CW-1:0]        before_hold;
    t_result              res;

    assign now_t   = TIME_BITS'(i_now_ms);
    assign changed = (i_raw_level != r_prev_level);
    assign pressed = (i_raw_level == i_cfg.pressed_level);

    // debounce: a change restarts the window and never counts as stable
    assign stable_for = now_t - r_last_change;
    assign stable     = !changed && (stable_for > TIME_BITS'(i_cfg.debounce_ms));

    // one phase timer, compared against hold or release gap by state
    assign phase_for   = now_t - r_phase_start;
    assign phase_limit = (r_state == ST_RELEASED) ? TIME_BITS'(i_cfg.release_gap_ms)
                                                  : TIME_BITS'(i_cfg.hold_ms);
    assign phase_done  = (phase_for >= phase_limit);
    assign before_hold = (r_count != '0) ? r_count - CNT_ONE : '0;

    // next state and result fields
    always_comb begin
        n_debounced   = r_debounced;
        n_state       = r_state;
        n_phase_start = r_phase_start;
        n_count       = r_count;
        res           = '0;
        if (stable) begin
            n_debounced = pressed;
            if (pressed) begin
                unique case (r_state)
                    ST_IDLE: begin
                        n_state         = ST_PRESSED;
                        n_phase_start   = now_t;
                        n_count         = CNT_ONE;
                        res.click_event = 1'b1;
                    end
                    ST_PRESSED: begin
                        if (phase_done) begin
                            n_state                      = ST_HELD;
                            n_phase_start                = now_t;
                            res.hold_event               = 1'b1;
                            res.clicks_before_hold_start = 4'(before_hold);
                        end
                    end
                    ST_HELD: begin
                        res.clicks_during_hold = 4'(before_hold);
                    end
                    default: begin
                        // released gap: next click of the series
                        n_state         = ST_PRESSED;
                        n_phase_start   = now_t;
                        n_count         = r_count + CNT_ONE;
                        res.click_event = 1'b1;
                    end
                endcase
            end else begin
                unique case (r_state)
                    ST_PRESSED: begin
                        if (r_count >= CNT_MAX) begin
                            // series full: report at once
                            n_state           = ST_IDLE;
                            res.series_clicks = 4'(r_count);
                            n_count           = '0;
                        end else begin
                            n_state = ST_RELEASED;
                        end
                        n_phase_start     = now_t;
                        res.release_event = 1'b1;
                    end
                    ST_HELD: begin
                        n_state           = ST_IDLE;
                        n_phase_start     = now_t;
                        n_count           = '0;
                        res.release_event = 1'b1;
                    end
                    ST_RELEASED: begin
                        if (phase_done) begin
                            n_state           = ST_IDLE;
                            n_phase_start     = now_t;
                            res.series_clicks = 4'(r_count);
                            n_count           = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        res.is_pressed = n_debounced;
    end

    // state update on each accepted poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b0;
            r_last_change <= '0;
            r_debounced   <= 1'b0;
            r_state       <= ST_IDLE;
            r_phase_start <= '0;
            r_count       <= '0;
        end else if (i_accept) begin
            r_prev_level <= i_raw_level;
            if (changed) begin
                r_last_change <= now_t;
            end
            r_debounced   <= n_debounced;
            r_state       <= n_state;
            r_phase_start <= n_phase_start;
            r_count       <= n_count;
        end
    end

    assign o_result = res;

endmodule

### design/bchm_outq.sv
// Two-entry result queue between the detector and the output stream.
// Depends on bchm_pkg (t_result).
module bchm_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bchm_pkg::t_result  i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop_ready,
    output bchm_pkg::t_result  o_data
);
    import bchm_pkg::*;

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_pop_ready;
    assign o_data  = r_mem[r_rptr];

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/button_click_hold_multiclick_fsm_core.sv
// Top level of the debounced button click / hold / multi-click detector.
// Depends on bchm_pkg, bchm_cfg_regs, bchm_detect and bchm_outq.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-----------------------------------
//  s poll   | in        | i_s_tvalid/o_s_tready| raw_level, now_ms
//  m result | out       | o_m_tvalid/i_m_tready| events, counts, is_pressed
//  apb cfg  | in        | psel/penable, pready | 4 registers at 0x0, 0x4, 0x8, 0xC
//
// One poll per cycle while the queue has room: the detector works out the
// result of a beat in the cycle it is accepted and its state is updated at
// that edge; the result is registered into the queue and read out from there.
// A two-entry result queue lets the input keep going while one result waits;
// the input stalls only with both entries held. Reset (synchronous) restores
// the register defaults and the idle state at once; no clearing pass.
module button_click_hold_multiclick_fsm_core #(
    parameter int MAX_CLICKS = 15,
    parameter int TIME_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] raw_level, [32:1] now_ms, [39:33] zero
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] click_event, [1] release_event, [2] hold_event, [6:3] series_clicks,
    // [10:7] clicks_before_hold_start, [14:11] clicks_during_hold, [15] is_pressed
    output logic [15:0] o_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import bchm_pkg::*;

    t_cfg    cfg;
    t_result det_result;
    t_result q_data;
    logic    q_full;
    logic    accept;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    bchm_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    bchm_detect #(
        .MAX_CLICKS (MAX_CLICKS),
        .TIME_BITS  (TIME_BITS)
    ) u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_raw_level (i_s_tdata[0]),
        .i_now_ms    (i_s_tdata[32:1]),
        .i_cfg       (cfg),
        .o_result    (det_result)
    );

    bchm_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (det_result),
        .o_full      (q_full),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_data      (q_data)
    );

    assign o_m_tdata = q_data;

endmodule

### design/bchm_checker.sv
// Port-level checks for the button detector, bound to the top level.
// Depends only on the top level's ports.
module bchm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // queue is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // a click leaves the button pressed; a release leaves it released
    a_event_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[0] || o_m_tdata[15]) && (!o_m_tdata[1] || !o_m_tdata[15]))
        else $error("event disagrees with debounced level");

    // a finished series is only reported while released, never with a click or hold
    a_series_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[6:3] != 4'd0)
            |-> !o_m_tdata[15] && !o_m_tdata[0] && !o_m_tdata[2])
        else $error("series reported while pressed");

endmodule

bind button_click_hold_multiclick_fsm_core bchm_checker u_bchm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
